@@ sv/ckvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ckvt_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 64;

    localparam int KEY_FIELD_W = 64;
    localparam int VAL_W       = 64;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int IN_BITS  = KEY_FIELD_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + VAL_W + STATUS_W + OCC_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_MODIFY = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_PRESENT   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        CMT_NONE,
        CMT_SHIFT,
        CMT_MODIFY,
        CMT_APPEND
    } commit_op_t;

    typedef struct packed {
        logic             active;
        logic             hit;
        logic [IDX_W-1:0] pos;
        logic [VAL_W-1:0] rd;
    } token_t;

    typedef struct packed {
        commit_op_t       op;
        logic [IDX_W-1:0] pos;
    } commit_t;

endpackage

`default_nettype wire

@@ sv/ckvt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ckvt_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ckvt_pkg::IDX_W-1:0]    cell_idx,
    input  wire logic [ckvt_pkg::CNT_W-1:0]    count,
    input  wire logic [ckvt_pkg::KEY_BITS-1:0] req_key,
    input  wire logic [ckvt_pkg::VAL_W-1:0]    req_value,
    input  wire ckvt_pkg::token_t              tok_in,
    output ckvt_pkg::token_t                   tok_out,
    input  wire ckvt_pkg::commit_t             cmt,
    input  wire logic [ckvt_pkg::KEY_BITS-1:0] nxt_key,
    input  wire logic [ckvt_pkg::VAL_W-1:0]    nxt_value,
    output logic [ckvt_pkg::KEY_BITS-1:0]      key,
    output logic [ckvt_pkg::VAL_W-1:0]         value
);

    logic [ckvt_pkg::KEY_BITS-1:0] key_reg;
    logic [ckvt_pkg::KEY_BITS-1:0] key_next;
    logic [ckvt_pkg::VAL_W-1:0]    value_reg;
    logic [ckvt_pkg::VAL_W-1:0]    value_next;
    logic                          active_reg;
    ckvt_pkg::token_t              tok_reg;
    ckvt_pkg::token_t              tok_next;
    logic                          match;

    // An entry takes part in the search only while it lies below the count.
    assign match = tok_in.active && !tok_in.hit
                   && (ckvt_pkg::CNT_W'(cell_idx) < count)
                   && (key_reg == req_key);

    always_comb
    begin
        tok_next.active = tok_in.active;
        tok_next.hit    = tok_in.hit | match;
        tok_next.pos    = match ? cell_idx : tok_in.pos;
        tok_next.rd     = match ? value_reg : tok_in.rd;
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        case (cmt.op)
            ckvt_pkg::CMT_SHIFT:
            begin
                if (cell_idx >= cmt.pos)
                begin
                    key_next   = nxt_key;
                    value_next = nxt_value;
                end
            end
            ckvt_pkg::CMT_MODIFY:
            begin
                if (cell_idx == cmt.pos)
                begin
                    value_next = req_value;
                end
            end
            ckvt_pkg::CMT_APPEND:
            begin
                if (cell_idx == cmt.pos)
                begin
                    key_next   = req_key;
                    value_next = req_value;
                end
            end
            default:
            begin
                key_next   = key_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= tok_next.active;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg   <= tok_next;
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = active_reg;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

@@ sv/compacting_key_value_table.sv @@
// Compacting key/value table. Each request is one transfer on the s_ side (kind in s_tuser,
// key and value in s_tdata) and gives exactly one result transfer on the m_ side. Entries
// sit in a row of cells in insertion order; a search token walks down the row one cell per
// clock; once it leaves the last cell the request waits to commit, which updates the table
// and loads the result into the output register. The block handles one request at a
// time. A finished result waits in the output register while the next request is taken,
// and the table is only updated once that register is free. The capacity register may be
// written only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module compacting_key_value_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ckvt_pkg::IN_W-1:0]     s_tdata,   // key, value
    input  wire logic [ckvt_pkg::KIND_W-1:0]   s_tuser,   // kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ckvt_pkg::OUT_W-1:0]         m_tdata,   // found, read_value, status, occupancy
    input  wire logic                          cfg_wr_en,
    input  wire logic [ckvt_pkg::CAP_W-1:0]    cfg_wr_data
);

    ckvt_pkg::state_t               state_reg;
    ckvt_pkg::state_t               state_next;
    logic [ckvt_pkg::CNT_W-1:0]     count_reg;
    logic [ckvt_pkg::CNT_W-1:0]     count_next;
    logic [ckvt_pkg::CAP_W-1:0]     cap_reg;
    logic                           start_reg;
    ckvt_pkg::kind_t                kind_reg;
    logic [ckvt_pkg::KEY_BITS-1:0]  key_reg;
    logic [ckvt_pkg::VAL_W-1:0]     value_reg;
    ckvt_pkg::token_t               fin_reg;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [ckvt_pkg::OUT_W-1:0]     m_data_reg;
    logic [ckvt_pkg::OUT_W-1:0]     m_data_next;

    logic                           accept;
    logic                           do_commit;
    logic                           full;
    ckvt_pkg::status_t              status;
    logic [ckvt_pkg::VAL_W-1:0]     rd;
    ckvt_pkg::commit_t              cmt;
    ckvt_pkg::token_t               tok_first;
    ckvt_pkg::token_t               tok_last;

    ckvt_pkg::token_t               tok [ckvt_pkg::DEPTH];
    logic [ckvt_pkg::KEY_BITS-1:0]  cell_key [ckvt_pkg::DEPTH];
    logic [ckvt_pkg::VAL_W-1:0]     cell_value [ckvt_pkg::DEPTH];

    assign tok_first = '{active: start_reg, hit: 1'b0, pos: '0, rd: '0};
    assign tok_last  = tok[ckvt_pkg::DEPTH-1];

    for (genvar i = 0; i < ckvt_pkg::DEPTH; i++)
    begin : g_cell
        ckvt_pkg::token_t              tok_in;
        logic [ckvt_pkg::KEY_BITS-1:0] nxt_key;
        logic [ckvt_pkg::VAL_W-1:0]    nxt_value;

        if (i == 0)
        begin : g_head
            assign tok_in = tok_first;
        end
        else
        begin : g_body
            assign tok_in = tok[i-1];
        end

        if (i == ckvt_pkg::DEPTH - 1)
        begin : g_tail
            assign nxt_key   = cell_key[i];
            assign nxt_value = cell_value[i];
        end
        else
        begin : g_link
            assign nxt_key   = cell_key[i+1];
            assign nxt_value = cell_value[i+1];
        end

        ckvt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (ckvt_pkg::IDX_W'(i)),
            .count     (count_reg),
            .req_key   (key_reg),
            .req_value (value_reg),
            .tok_in    (tok_in),
            .tok_out   (tok[i]),
            .cmt       (cmt),
            .nxt_key   (nxt_key),
            .nxt_value (nxt_value),
            .key       (cell_key[i]),
            .value     (cell_value[i])
        );
    end

    // The effective limit is the smaller of the capacity register and the built depth.
    assign full = (ckvt_pkg::CMP_W'(count_reg) >= ckvt_pkg::CMP_W'(cap_reg))
                  || (count_reg == ckvt_pkg::CNT_W'(ckvt_pkg::DEPTH));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ckvt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ckvt_pkg::ST_SCAN;
                end
            end
            ckvt_pkg::ST_SCAN:
            begin
                if (tok_last.active)
                begin
                    state_next = ckvt_pkg::ST_COMMIT;
                end
            end
            ckvt_pkg::ST_COMMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ckvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ckvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == ckvt_pkg::ST_IDLE);
        accept    = s_tready && s_tvalid;
        do_commit = (state_reg == ckvt_pkg::ST_COMMIT) && (!m_valid_reg || m_tready);
    end

    always_comb
    begin
        status     = ckvt_pkg::STAT_DONE;
        rd         = '0;
        count_next = count_reg;
        cmt.op     = ckvt_pkg::CMT_NONE;
        cmt.pos    = fin_reg.pos;
        case (kind_reg)
            ckvt_pkg::KIND_ADD:
            begin
                if (fin_reg.hit)
                begin
                    status = ckvt_pkg::STAT_PRESENT;
                end
                else if (full)
                begin
                    status = ckvt_pkg::STAT_FULL;
                end
                else
                begin
                    cmt.op     = ckvt_pkg::CMT_APPEND;
                    cmt.pos    = count_reg[ckvt_pkg::IDX_W-1:0];
                    count_next = count_reg + ckvt_pkg::CNT_W'(1);
                end
            end
            ckvt_pkg::KIND_REMOVE:
            begin
                if (fin_reg.hit)
                begin
                    cmt.op     = ckvt_pkg::CMT_SHIFT;
                    count_next = count_reg - ckvt_pkg::CNT_W'(1);
                end
                else
                begin
                    status = ckvt_pkg::STAT_NOT_FOUND;
                end
            end
            ckvt_pkg::KIND_LOOKUP:
            begin
                if (fin_reg.hit)
                begin
                    rd = fin_reg.rd;
                end
                else
                begin
                    status = ckvt_pkg::STAT_NOT_FOUND;
                end
            end
            ckvt_pkg::KIND_MODIFY:
            begin
                if (fin_reg.hit)
                begin
                    cmt.op = ckvt_pkg::CMT_MODIFY;
                end
                else
                begin
                    status = ckvt_pkg::STAT_NOT_FOUND;
                end
            end
            default:
            begin
                status = ckvt_pkg::STAT_DONE;
            end
        endcase
        if (!do_commit)
        begin
            cmt.op     = ckvt_pkg::CMT_NONE;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (do_commit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = ckvt_pkg::OUT_W'({ckvt_pkg::OCC_W'(count_next), status, rd,
                                             fin_reg.hit});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ckvt_pkg::ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= ckvt_pkg::CAP_RESET;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            start_reg   <= accept;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        if (accept)
        begin
            kind_reg  <= ckvt_pkg::kind_t'(s_tuser);
            key_reg   <= s_tdata[ckvt_pkg::KEY_BITS-1:0];
            value_reg <= s_tdata[ckvt_pkg::KEY_FIELD_W +: ckvt_pkg::VAL_W];
        end
        if ((state_reg == ckvt_pkg::ST_SCAN) && tok_last.active)
        begin
            fin_reg <= tok_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ sv/ckvt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ckvt_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [ckvt_pkg::OUT_W-1:0]  m_tdata
);

    logic                              found;
    logic [ckvt_pkg::VAL_W-1:0]        read_value;
    logic [ckvt_pkg::STATUS_W-1:0]     status;
    logic [ckvt_pkg::OCC_W-1:0]        occupancy;

    assign found      = m_tdata[0];
    assign read_value = m_tdata[1 +: ckvt_pkg::VAL_W];
    assign status     = m_tdata[1 + ckvt_pkg::VAL_W +: ckvt_pkg::STATUS_W];
    assign occupancy  = m_tdata[1 + ckvt_pkg::VAL_W + ckvt_pkg::STATUS_W +: ckvt_pkg::OCC_W];

    // A stalled result must stay and hold its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // Requests are served one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

    // A present key always ends as done or as an ignored add.
    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && found |->
            (status == ckvt_pkg::STAT_DONE) || (status == ckvt_pkg::STAT_PRESENT))
        else $error("found key with a not-found or full status");

    // A nonzero read value comes only from a successful lookup.
    a_read_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (read_value != '0) |-> found && (status == ckvt_pkg::STAT_DONE))
        else $error("read value without a successful lookup");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (ckvt_pkg::CNT_W'(occupancy) <= ckvt_pkg::CNT_W'(ckvt_pkg::DEPTH)))
        else $error("occupancy beyond the table depth");

endmodule

bind compacting_key_value_table ckvt_checker u_ckvt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import ckvt_pkg::*;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  SETTLE_CYCLES = DEPTH + 8;
    localparam int  HOLD_CYCLES   = 400;
    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
    localparam logic [63:0] KEY_ZERO = 64'h0;
    localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_TOP  = 64'h8000_0000_0000_0000;

    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_RARE   = 2;

    typedef struct {
        kind_t       op;
        logic [63:0] key;
        logic [63:0] value;
    } table_req_t;

    typedef struct {
        logic        found;
        logic [63:0] read_value;
        status_t     status;
        logic [4:0]  occupancy;
    } table_resp_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic [KIND_W-1:0]   s_tuser = '0;
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    wire  [OUT_W-1:0]    m_tdata;
    logic                cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data = '0;

    compacting_key_value_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    table_req_t  pending_reqs[$];
    table_resp_t expected_results[$];

    logic [63:0] held_keys[DEPTH];
    logic [63:0] held_values[DEPTH];
    int          held_count = 0;
    logic [4:0]  capacity_reg = CAP_RESET;

    logic [63:0] key_pool[32];
    int          pool_size = 0;

    int error_count = 0;
    int cycle_count = 0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;
    int ready_mode = READY_ALWAYS;
    int mode_left = 0;
    int burst_left = 0;
    int gap_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic table_resp_t predict_table_op(kind_t op, logic [63:0] key_in,
                                                     logic [63:0] val);
        table_resp_t r;
        logic [63:0] k;
        int limit;
        int pos;
        int j;
        k = key_in & KEY_MASK;
        limit = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
        pos = held_count;
        for (j = held_count - 1; j >= 0; j--)
        begin
            if (held_keys[j] == k)
                pos = j;
        end
        r.found = (pos < held_count);
        r.read_value = '0;
        r.status = STAT_DONE;
        case (op)
            KIND_ADD:
            begin
                if (r.found)
                    r.status = STAT_PRESENT;
                else if (held_count >= limit)
                    r.status = STAT_FULL;
                else
                begin
                    held_keys[held_count] = k;
                    held_values[held_count] = val;
                    held_count++;
                end
            end
            KIND_REMOVE:
            begin
                if (r.found)
                begin
                    for (j = pos; j < held_count - 1; j++)
                    begin
                        held_keys[j] = held_keys[j + 1];
                        held_values[j] = held_values[j + 1];
                    end
                    held_count--;
                end
                else
                    r.status = STAT_NOT_FOUND;
            end
            KIND_LOOKUP:
            begin
                if (r.found)
                    r.read_value = held_values[pos];
                else
                    r.status = STAT_NOT_FOUND;
            end
            default:
            begin
                if (r.found)
                    held_values[pos] = val;
                else
                    r.status = STAT_NOT_FOUND;
            end
        endcase
        r.occupancy = held_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Sender: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        table_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_table_op(kind_t'(s_tuser),
                                                            s_tdata[63:0],
                                                            s_tdata[127:64]));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_W'({req.value, req.key});
                    s_tuser  <= req.op;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 10)
                                                               : $urandom_range(6);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(25, 1);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern of its own, plus long hold-offs on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_asks != hold_served)
        begin
            hold_served = hold_asks;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(2);
                mode_left = $urandom_range(80, 5);
            end
            mode_left--;
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(1));
                default:      m_tready <= ($urandom_range(5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        table_resp_t exp_r;
        logic        got_found;
        logic [63:0] got_value;
        logic [1:0]  got_status;
        logic [4:0]  got_occ;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_found  = m_tdata[0];
            got_value  = m_tdata[VAL_W:1];
            got_status = m_tdata[VAL_W+2:VAL_W+1];
            got_occ    = m_tdata[VAL_W+7:VAL_W+3];
            if (expected_results.size() == 0)
                report_mismatch("result transfer with no request outstanding");
            else
            begin
                exp_r = expected_results.pop_front();
                if (got_found !== exp_r.found)
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              got_found, exp_r.found));
                if (got_value !== exp_r.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              got_value, exp_r.read_value));
                if (got_status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              got_status, exp_r.status.name()));
                if (got_occ !== exp_r.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              got_occ, exp_r.occupancy));
            end
        end
    end

    task automatic queue_req(input kind_t op, input logic [63:0] key, input logic [63:0] val);
        table_req_t req;
        req.op = op;
        req.key = key;
        req.value = val;
        pending_reqs.push_back(req);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_reg = cap;
    endtask

    task automatic new_key_pool(input int n);
        int i;
        pool_size = n;
        for (i = 0; i < n; i++)
            key_pool[i] = rand64();
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
    endtask

    task automatic queue_random_ops(input int n, input int add_pct);
        int i;
        int r;
        kind_t op;
        logic [63:0] key;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < add_pct)
                op = KIND_ADD;
            else
            begin
                case (((r - add_pct) * 3) / (100 - add_pct))
                    0:       op = KIND_REMOVE;
                    1:       op = KIND_LOOKUP;
                    default: op = KIND_MODIFY;
                endcase
            end
            if ($urandom_range(9) == 0)
                key = rand64();
            else
                key = key_pool[$urandom_range(pool_size - 1)];
            queue_req(op, key, rand64());
        end
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table at the reset capacity, then insert, shift and modify.
        queue_req(KIND_LOOKUP, KEY_ZERO, rand64());
        queue_req(KIND_REMOVE, KEY_ZERO, rand64());
        queue_req(KIND_MODIFY, KEY_ZERO, rand64());
        queue_req(KIND_ADD,    KEY_ZERO, KEY_ONES);
        queue_req(KIND_ADD,    KEY_ONES, KEY_ZERO);
        queue_req(KIND_ADD,    KEY_TOP,  64'h0123_4567_89AB_CDEF);
        queue_req(KIND_ADD,    KEY_ZERO, 64'h5);
        queue_req(KIND_LOOKUP, KEY_ZERO, rand64());
        queue_req(KIND_LOOKUP, KEY_ONES, rand64());
        queue_req(KIND_MODIFY, KEY_ONES, KEY_ONES);
        queue_req(KIND_LOOKUP, KEY_ONES, rand64());
        queue_req(KIND_REMOVE, KEY_ZERO, rand64());
        queue_req(KIND_LOOKUP, KEY_TOP,  rand64());
        queue_req(KIND_LOOKUP, KEY_ZERO, rand64());
        queue_req(KIND_ADD,    KEY_ZERO, 64'h7);
        queue_req(KIND_REMOVE, KEY_TOP,  rand64());
        queue_req(KIND_LOOKUP, KEY_ZERO, rand64());
        queue_req(KIND_REMOVE, KEY_ZERO, rand64());
        queue_req(KIND_REMOVE, KEY_ONES, rand64());

        // Small table: full, and present while full.
        write_capacity(5'd2);
        queue_req(KIND_ADD,    64'hA, rand64());
        queue_req(KIND_ADD,    64'hB, rand64());
        queue_req(KIND_ADD,    64'hC, rand64());
        queue_req(KIND_ADD,    64'hA, rand64());
        queue_req(KIND_REMOVE, 64'hA, rand64());
        queue_req(KIND_ADD,    64'hC, rand64());

        // Zero capacity with entries still held.
        write_capacity(5'd0);
        queue_req(KIND_ADD,    64'hD, rand64());
        queue_req(KIND_LOOKUP, 64'hB, rand64());
        queue_req(KIND_MODIFY, 64'hB, rand64());
        queue_req(KIND_LOOKUP, 64'hB, rand64());

        // Capacity above depth saturates at the depth.
        write_capacity(5'd31);
        new_key_pool(24);
        queue_random_ops(130, 55);

        write_capacity(5'd1);
        new_key_pool(4);
        queue_random_ops(60, 40);

        // Long receiver hold-off so the block backs up its input.
        write_capacity(5'd16);
        new_key_pool(20);
        queue_random_ops(150, 45);
        hold_asks++;

        write_capacity(5'd17);
        new_key_pool(22);
        queue_random_ops(80, 50);

        // Lower the capacity below the number of entries held.
        write_capacity(5'd16);
        new_key_pool(12);
        for (i = 0; i < 10; i++)
            queue_req(KIND_ADD, key_pool[i], rand64());
        write_capacity(5'd3);
        queue_random_ops(60, 35);

        write_capacity(5'd8);
        new_key_pool(14);
        queue_random_ops(120, 45);

        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding at end of run");
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
